// File: design/kline_slow_init_connect_defines.svh
// Assertion macros shared by the slow-init connect block
`ifndef KLINE_SLOW_INIT_CONNECT_DEFINES_SVH
`define KLINE_SLOW_INIT_CONNECT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset
`define KSC_ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("kscon assertion failed");

// Check that a condition never holds outside reset
`define KSC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`KSC_ASSERT_CLK(lbl, clk, rst_n, !(cond))

`else

`define KSC_ASSERT_CLK(lbl, clk, rst_n, prop)
`define KSC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: design/kscon_pkg.sv
// Types and constants of the slow-init connect block
package kscon_pkg;

	// Command codes of an input word
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_BYTE  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_ECU_ADDRESS  = 2'd0;
	localparam logic [1:0] REG_BIT_TIME     = 2'd1;
	localparam logic [1:0] REG_IDLE_TIME    = 2'd2;
	localparam logic [1:0] REG_SYNC_LIMIT   = 2'd3;

	// Configuration reset values
	localparam logic [7:0]  ECU_ADDRESS_RST = 8'd1;
	localparam logic [9:0]  BIT_TIME_RST    = 10'd200;
	localparam logic [15:0] IDLE_TIME_RST   = 16'd2000;
	localparam logic [7:0]  SYNC_LIMIT_RST  = 8'd12;

	// Protocol bytes
	localparam logic [7:0] SYNC_BYTE   = 8'h55;
	localparam logic [7:0] KEYWORD_ONE = 8'h52;
	localparam logic [7:0] KEYWORD_TWO = 8'h80;
	localparam logic [7:0] KW_ANSWER   = 8'h7F;
	localparam logic [7:0] TITLE_BYTE  = 8'hA0;

	// Status codes
	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_BUSY      = 3'd1;
	localparam logic [2:0] ST_CONNECTED = 3'd2;
	localparam logic [2:0] ST_NO_SYNC   = 3'd3;
	localparam logic [2:0] ST_BAD_KW    = 3'd4;
	localparam logic [2:0] ST_BAD_TITLE = 3'd5;

	// One result word
	typedef struct packed {
		logic       line_level;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       id_valid;
		logic [7:0] id_byte;
		logic [2:0] status;
		logic [7:0] check_first;
		logic [7:0] check_last;
	} kscon_res_t;

endpackage

// File: design/kscon_seq.sv
// Connect sequencer: configuration registers, phase state and per-word result logic
`include "kline_slow_init_connect_defines.svh"

module kscon_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  logic [1:0]         cmd,
	input  logic [7:0]         rx_byte,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output kscon_pkg::kscon_res_t res
);
	import kscon_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_IDLELINE, PH_BITS, PH_SYNC, PH_KW1, PH_KW2,
		PH_HEADER, PH_ID, PH_CONNECTED, PH_NOSYNC, PH_BADKW, PH_BADTITLE
	} phase_t;

	logic [7:0]  ecu_address_q;
	logic [9:0]  bit_time_q;
	logic [15:0] idle_time_q;
	logic [7:0]  sync_limit_q;

	phase_t      phase_q, phase_n;
	logic [15:0] tick_q, tick_n, tick_inc;
	logic [3:0]  bit_idx_q, bit_idx_n;
	logic [7:0]  search_q, search_n, search_inc;
	logic [7:0]  kw_first_q, kw_first_n;
	logic [1:0]  hdr_idx_q, hdr_idx_n;
	logic [7:0]  blk_len_q, blk_len_n;
	logic [7:0]  byte_cnt_q, byte_cnt_n, byte_inc;
	logic [7:0]  chk_first_q, chk_first_n;
	logic [7:0]  chk_last_q, chk_last_n;
	logic [9:0]  bit_time_eff;
	logic [2:0]  addr_bit;
	logic        txv, idv;
	logic [7:0]  idb;

	assign tick_inc     = tick_q + 16'd1;
	assign search_inc   = search_q + 8'd1;
	assign byte_inc     = byte_cnt_q + 8'd1;
	assign bit_time_eff = (bit_time_q == 10'd0) ? 10'd1 : bit_time_q;

	// Compute next state and the side outputs of this word
	always_comb begin
		phase_n     = phase_q;
		tick_n      = tick_q;
		bit_idx_n   = bit_idx_q;
		search_n    = search_q;
		kw_first_n  = kw_first_q;
		hdr_idx_n   = hdr_idx_q;
		blk_len_n   = blk_len_q;
		byte_cnt_n  = byte_cnt_q;
		chk_first_n = chk_first_q;
		chk_last_n  = chk_last_q;
		txv         = 1'b0;
		idv         = 1'b0;
		idb         = 8'd0;
		unique case (cmd)
			CMD_START: begin
				tick_n      = 16'd0;
				bit_idx_n   = 4'd0;
				search_n    = 8'd0;
				kw_first_n  = 8'd0;
				hdr_idx_n   = 2'd0;
				blk_len_n   = 8'd0;
				byte_cnt_n  = 8'd0;
				chk_first_n = 8'd0;
				chk_last_n  = 8'd0;
				phase_n     = (idle_time_q == 16'd0) ? PH_BITS : PH_IDLELINE;
			end
			CMD_TICK: begin
				if (phase_q == PH_IDLELINE) begin
					tick_n = tick_inc;
					if (tick_inc >= idle_time_q) begin
						tick_n    = 16'd0;
						bit_idx_n = 4'd0;
						phase_n   = PH_BITS;
					end
				end else if (phase_q == PH_BITS) begin
					tick_n = tick_inc;
					if (tick_inc >= {6'd0, bit_time_eff}) begin
						tick_n = 16'd0;
						if (bit_idx_q >= 4'd9) begin
							// stop bit done: start looking for sync
							bit_idx_n = 4'd0;
							search_n  = 8'd0;
							phase_n   = (sync_limit_q == 8'd0) ? PH_NOSYNC : PH_SYNC;
						end else begin
							bit_idx_n = bit_idx_q + 4'd1;
						end
					end
				end
			end
			CMD_BYTE: begin
				unique case (phase_q)
					PH_SYNC: begin
						if (rx_byte == SYNC_BYTE) begin
							phase_n = PH_KW1;
						end else begin
							search_n = search_inc;
							if (search_inc >= sync_limit_q) phase_n = PH_NOSYNC;
						end
					end
					PH_KW1: begin
						kw_first_n = rx_byte;
						phase_n    = PH_KW2;
					end
					PH_KW2: begin
						if (kw_first_q == KEYWORD_ONE && rx_byte == KEYWORD_TWO) begin
							txv       = 1'b1;
							hdr_idx_n = 2'd0;
							phase_n   = PH_HEADER;
						end else begin
							phase_n = PH_BADKW;
						end
					end
					PH_HEADER: begin
						if (hdr_idx_q == 2'd0) begin
							hdr_idx_n = 2'd1;
						end else if (hdr_idx_q == 2'd1) begin
							blk_len_n = rx_byte;
							hdr_idx_n = 2'd2;
						end else if (rx_byte != TITLE_BYTE) begin
							phase_n = PH_BADTITLE;
						end else begin
							byte_cnt_n = 8'd0;
							phase_n    = (blk_len_q == 8'd0) ? PH_CONNECTED : PH_ID;
						end
					end
					PH_ID: begin
						// all but the last two block bytes are reported
						if (({1'b0, byte_cnt_q} + 9'd2) < {1'b0, blk_len_q}) begin
							idv = 1'b1;
							idb = rx_byte;
						end
						chk_first_n = chk_last_q;
						chk_last_n  = rx_byte;
						byte_cnt_n  = byte_inc;
						if (byte_inc >= blk_len_q) phase_n = PH_CONNECTED;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign addr_bit = bit_idx_n[2:0] - 3'd1;

	// Build the result word from the state after this word
	always_comb begin
		if (phase_n != PH_BITS) begin
			res.line_level = 1'b1;
		end else if (bit_idx_n == 4'd0) begin
			res.line_level = 1'b0;
		end else if (bit_idx_n >= 4'd9) begin
			res.line_level = 1'b1;
		end else begin
			res.line_level = ecu_address_q[addr_bit];
		end
		res.tx_valid    = txv;
		res.tx_byte     = txv ? KW_ANSWER : 8'd0;
		res.id_valid    = idv;
		res.id_byte     = idb;
		res.check_first = chk_first_n;
		res.check_last  = chk_last_n;
		unique case (phase_n)
			PH_IDLE:      res.status = ST_IDLE;
			PH_CONNECTED: res.status = ST_CONNECTED;
			PH_NOSYNC:    res.status = ST_NO_SYNC;
			PH_BADKW:     res.status = ST_BAD_KW;
			PH_BADTITLE:  res.status = ST_BAD_TITLE;
			default:      res.status = ST_BUSY;
		endcase
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecu_address_q <= ECU_ADDRESS_RST;
			bit_time_q    <= BIT_TIME_RST;
			idle_time_q   <= IDLE_TIME_RST;
			sync_limit_q  <= SYNC_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ECU_ADDRESS: ecu_address_q <= cfg_data[7:0];
				REG_BIT_TIME:    bit_time_q    <= cfg_data[9:0];
				REG_IDLE_TIME:   idle_time_q   <= cfg_data;
				REG_SYNC_LIMIT:  sync_limit_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Advance sequencer state once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= 16'd0;
			bit_idx_q   <= 4'd0;
			search_q    <= 8'd0;
			kw_first_q  <= 8'd0;
			hdr_idx_q   <= 2'd0;
			blk_len_q   <= 8'd0;
			byte_cnt_q  <= 8'd0;
			chk_first_q <= 8'd0;
			chk_last_q  <= 8'd0;
		end else if (step_en) begin
			phase_q     <= phase_n;
			tick_q      <= tick_n;
			bit_idx_q   <= bit_idx_n;
			search_q    <= search_n;
			kw_first_q  <= kw_first_n;
			hdr_idx_q   <= hdr_idx_n;
			blk_len_q   <= blk_len_n;
			byte_cnt_q  <= byte_cnt_n;
			chk_first_q <= chk_first_n;
			chk_last_q  <= chk_last_n;
		end
	end

	`KSC_ASSERT_CLK(a_tx_from_kw2, clk, arst_n, (step_en && res.tx_valid) |-> (phase_q == PH_KW2))
	`KSC_ASSERT_CLK(a_id_from_id, clk, arst_n, (step_en && res.id_valid) |-> (phase_q == PH_ID))
	`KSC_ASSERT_NEVER(a_bit_range, clk, arst_n, bit_idx_q > 4'd9)
	`KSC_ASSERT_NEVER(a_id_len, clk, arst_n, (phase_q == PH_ID) && (blk_len_q == 8'd0))

endmodule

// File: design/kline_slow_init_connect.sv
// Top level of the K-line slow-init connect sequencer
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  input    | in_valid / in_stall | cmd, rx_byte
//  result   | out_valid/out_stall | line_level, tx_valid, tx_byte, id_valid, id_byte,
//           |                     | status, check_first, check_last
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One input word per cycle while in_stall is low; each accepted word's result is
// registered into the output register, or into the skid register if that is stalled.
// The sequencer logic sits between the state registers and the result register; a
// one-word skid register keeps input open while the result waits, so in_stall rises
// only when both output slots are full. Configuration writes are always ready. Reset
// restores config defaults, idle phase and empty slots at once; no clearing is needed.
`include "kline_slow_init_connect_defines.svh"

module kline_slow_init_connect (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        line_level,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        id_valid,
	output logic [7:0]  id_byte,
	output logic [2:0]  status,
	output logic [7:0]  check_first,
	output logic [7:0]  check_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import kscon_pkg::*;

	kscon_res_t res_new;
	kscon_res_t res_s1;
	kscon_res_t skid_q;
	logic       res_valid_s1;
	logic       skid_valid_q;
	logic       in_accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !skid_valid_q;

	kscon_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (in_accept),
		.cmd       (cmd),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res_new)
	);

	// Track output and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (res_valid_s1 && out_stall) begin
			if (in_accept) skid_valid_q <= 1'b1;
		end else if (skid_valid_q) begin
			res_valid_s1 <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			res_valid_s1 <= in_accept;
		end
	end

	// Move result words into the output and skid registers
	always_ff @(posedge clk) begin
		if (res_valid_s1 && out_stall) begin
			if (in_accept) skid_q <= res_new;
		end else if (skid_valid_q) begin
			res_s1 <= skid_q;
		end else if (in_accept) begin
			res_s1 <= res_new;
		end
	end

	assign out_valid   = res_valid_s1;
	assign line_level  = res_s1.line_level;
	assign tx_valid    = res_s1.tx_valid;
	assign tx_byte     = res_s1.tx_byte;
	assign id_valid    = res_s1.id_valid;
	assign id_byte     = res_s1.id_byte;
	assign status      = res_s1.status;
	assign check_first = res_s1.check_first;
	assign check_last  = res_s1.check_last;

	`KSC_ASSERT_NEVER(a_skid_needs_out, clk, arst_n, skid_valid_q && !res_valid_s1)
	`KSC_ASSERT_CLK(a_skid_fill, clk, arst_n, $rose(skid_valid_q) |-> $past(res_valid_s1 && out_stall))
	`KSC_ASSERT_CLK(a_tx_busy, clk, arst_n, (res_valid_s1 && res_s1.tx_valid) |-> (res_s1.status == ST_BUSY))
	`KSC_ASSERT_CLK(a_id_state, clk, arst_n, (res_valid_s1 && res_s1.id_valid) |-> (res_s1.status == ST_BUSY || res_s1.status == ST_CONNECTED))

endmodule

// File: test/kline_slow_init_connect_test.sv
// Self-checking testbench of the K-line slow-init connect sequencer
module kline_slow_init_connect_test;
	import kscon_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEMS_PER_MODE = 140;

	// Sequencer phases of the predictor
	typedef enum logic [3:0] {
		SEQ_IDLE, SEQ_IDLE_LINE, SEQ_INIT_BITS, SEQ_SYNC_HUNT, SEQ_KEY_FIRST,
		SEQ_KEY_SECOND, SEQ_HEADER, SEQ_IDENT, SEQ_CONNECTED, SEQ_NO_SYNC,
		SEQ_BAD_KEY, SEQ_BAD_TITLE
	} seq_phase_t;

	// Ways a connect sequence may be broken
	typedef enum int {
		FLT_NONE, FLT_NO_SYNC, FLT_KEY_FIRST, FLT_KEY_SECOND, FLT_TITLE, FLT_RESTART
	} fault_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic        line_level;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        id_valid;
	logic [7:0]  id_byte;
	logic [2:0]  status;
	logic [7:0]  check_first;
	logic [7:0]  check_last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// Predictor configuration and state
	logic [7:0]  cfg_ecu_addr;
	logic [9:0]  cfg_bit_ticks;
	logic [15:0] cfg_idle_ticks;
	logic [7:0]  cfg_sync_limit;
	seq_phase_t  seq_phase;
	logic [15:0] tick_cnt;
	logic [3:0]  bit_idx;
	logic [7:0]  hunt_cnt;
	logic [7:0]  kw_first;
	logic [1:0]  hdr_idx;
	logic [7:0]  blk_len;
	logic [7:0]  rx_cnt;
	logic [7:0]  hold_chk_first;
	logic [7:0]  hold_chk_last;

	kscon_res_t pending_words[$];
	int error_count = 0;
	int useful_items = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;

	kline_slow_init_connect DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.line_level(line_level),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.id_valid(id_valid),
		.id_byte(id_byte),
		.status(status),
		.check_first(check_first),
		.check_last(check_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Clear the per-connection state
	function automatic void clear_run();
		tick_cnt = '0;
		bit_idx = '0;
		hunt_cnt = '0;
		kw_first = '0;
		hdr_idx = '0;
		blk_len = '0;
		rx_cnt = '0;
		hold_chk_first = '0;
		hold_chk_last = '0;
	endfunction

	// Advance the predictor by one input word and build the result word
	function automatic kscon_res_t next_result_word(logic [1:0] c, logic [7:0] b);
		kscon_res_t w;
		logic [9:0] bt;
		logic txv;
		w = '0;
		txv = 1'b0;
		case (c)
			CMD_START: begin
				clear_run();
				seq_phase = (cfg_idle_ticks == 16'd0) ? SEQ_INIT_BITS : SEQ_IDLE_LINE;
			end
			CMD_TICK: begin
				if (seq_phase == SEQ_IDLE_LINE) begin
					tick_cnt = tick_cnt + 16'd1;
					if (tick_cnt >= cfg_idle_ticks) begin
						tick_cnt = '0;
						bit_idx = '0;
						seq_phase = SEQ_INIT_BITS;
					end
				end else if (seq_phase == SEQ_INIT_BITS) begin
					bt = (cfg_bit_ticks == 10'd0) ? 10'd1 : cfg_bit_ticks;
					tick_cnt = tick_cnt + 16'd1;
					if (tick_cnt >= {6'd0, bt}) begin
						tick_cnt = '0;
						if (bit_idx >= 4'd9) begin
							bit_idx = '0;
							hunt_cnt = '0;
							seq_phase = (cfg_sync_limit == 8'd0) ? SEQ_NO_SYNC : SEQ_SYNC_HUNT;
						end else begin
							bit_idx = bit_idx + 4'd1;
						end
					end
				end
			end
			CMD_BYTE: begin
				case (seq_phase)
					SEQ_SYNC_HUNT: begin
						if (b == SYNC_BYTE) begin
							seq_phase = SEQ_KEY_FIRST;
						end else begin
							hunt_cnt = hunt_cnt + 8'd1;
							if (hunt_cnt >= cfg_sync_limit)
								seq_phase = SEQ_NO_SYNC;
						end
					end
					SEQ_KEY_FIRST: begin
						kw_first = b;
						seq_phase = SEQ_KEY_SECOND;
					end
					SEQ_KEY_SECOND: begin
						if (kw_first == KEYWORD_ONE && b == KEYWORD_TWO) begin
							txv = 1'b1;
							hdr_idx = '0;
							seq_phase = SEQ_HEADER;
						end else begin
							seq_phase = SEQ_BAD_KEY;
						end
					end
					SEQ_HEADER: begin
						if (hdr_idx == 2'd0) begin
							hdr_idx = 2'd1;
						end else if (hdr_idx == 2'd1) begin
							blk_len = b;
							hdr_idx = 2'd2;
						end else if (b != TITLE_BYTE) begin
							seq_phase = SEQ_BAD_TITLE;
						end else begin
							rx_cnt = '0;
							seq_phase = (blk_len == 8'd0) ? SEQ_CONNECTED : SEQ_IDENT;
						end
					end
					SEQ_IDENT: begin
						if (int'(rx_cnt) + 2 < int'(blk_len)) begin
							w.id_valid = 1'b1;
							w.id_byte = b;
						end
						hold_chk_first = hold_chk_last;
						hold_chk_last = b;
						rx_cnt = rx_cnt + 8'd1;
						if (rx_cnt >= blk_len)
							seq_phase = SEQ_CONNECTED;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// Derive the line level from the init frame position
		if (seq_phase != SEQ_INIT_BITS)
			w.line_level = 1'b1;
		else if (bit_idx == 4'd0)
			w.line_level = 1'b0;
		else if (bit_idx >= 4'd9)
			w.line_level = 1'b1;
		else
			w.line_level = cfg_ecu_addr[3'(bit_idx - 4'd1)];

		w.tx_valid = txv;
		w.tx_byte = txv ? KW_ANSWER : 8'h00;
		case (seq_phase)
			SEQ_IDLE:      w.status = ST_IDLE;
			SEQ_CONNECTED: w.status = ST_CONNECTED;
			SEQ_NO_SYNC:   w.status = ST_NO_SYNC;
			SEQ_BAD_KEY:   w.status = ST_BAD_KW;
			SEQ_BAD_TITLE: w.status = ST_BAD_TITLE;
			default:       w.status = ST_BUSY;
		endcase
		w.check_first = hold_chk_first;
		w.check_last = hold_chk_last;
		return w;
	endfunction

	function automatic logic [7:0] byte_except(logic [7:0] x);
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (b == x)
			b = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic report_error(string msg);
		$display("ERROR at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		kscon_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				report_error("result word with no prediction pending");
			end else begin
				want = pending_words.pop_front();
				check_field("line_level", 8'(line_level), 8'(want.line_level));
				check_field("tx_valid", 8'(tx_valid), 8'(want.tx_valid));
				check_field("tx_byte", tx_byte, want.tx_byte);
				check_field("id_valid", 8'(id_valid), 8'(want.id_valid));
				check_field("id_byte", id_byte, want.id_byte);
				check_field("status", 8'(status), 8'(want.status));
				check_field("check_first", check_first, want.check_first);
				check_field("check_last", check_last, want.check_last);
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(0, 99) < rx_stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Send one input word; enter and leave at a falling edge with valid held
	task automatic send_word(logic [1:0] c, logic [7:0] b, bit counts);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_words.push_back(next_result_word(c, b));
		if (counts)
			useful_items++;
		@(negedge clk);
	endtask

	// Send a word the sequencer should drop in the current phase
	task automatic send_noise(bit as_tick);
		logic [1:0] c;
		if ($urandom_range(0, 1) == 0)
			c = 2'd3;
		else
			c = as_tick ? CMD_TICK : CMD_BYTE;
		send_word(c, 8'($urandom_range(0, 255)), 1'b0);
	endtask

	// Hold input until every predicted word has come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Write all four registers back to back; call only while idle
	task automatic write_config(logic [7:0] ecu, logic [9:0] bt, logic [15:0] idle,
			logic [7:0] lim);
		logic [1:0]  idx[4];
		logic [15:0] val[4];
		idx = '{REG_ECU_ADDRESS, REG_BIT_TIME, REG_IDLE_TIME, REG_SYNC_LIMIT};
		val = '{{8'd0, ecu}, {6'd0, bt}, idle, {8'd0, lim}};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx[i])
				REG_ECU_ADDRESS: cfg_ecu_addr = val[i][7:0];
				REG_BIT_TIME:    cfg_bit_ticks = val[i][9:0];
				REG_IDLE_TIME:   cfg_idle_ticks = val[i];
				REG_SYNC_LIMIT:  cfg_sync_limit = val[i][7:0];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic tick_run(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_noise(1'b0);
			send_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	task automatic send_rx(logic [7:0] b);
		if ($urandom_range(0, 11) == 0)
			send_noise(1'b1);
		send_word(CMD_BYTE, b, 1'b1);
	endtask

	// Run one connect sequence under the current settings
	task automatic drive_connect(fault_t f, int n_junk, int len);
		int n_ticks;
		n_ticks = int'(cfg_idle_ticks) +
			10 * ((cfg_bit_ticks == 10'd0) ? 1 : int'(cfg_bit_ticks));
		send_word(CMD_START, 8'($urandom_range(0, 255)), 1'b1);
		if (f == FLT_RESTART) begin
			tick_run($urandom_range(0, n_ticks));
			send_word(CMD_START, 8'($urandom_range(0, 255)), 1'b1);
		end
		tick_run(n_ticks);
		if (cfg_sync_limit == 8'd0) begin
			send_rx(SYNC_BYTE);
			return;
		end
		for (int i = 0; i < n_junk; i++)
			send_rx(byte_except(SYNC_BYTE));
		if (f == FLT_NO_SYNC)
			return;
		send_rx(SYNC_BYTE);
		send_rx((f == FLT_KEY_FIRST) ? byte_except(KEYWORD_ONE) : KEYWORD_ONE);
		send_rx((f == FLT_KEY_SECOND) ? byte_except(KEYWORD_TWO) : KEYWORD_TWO);
		if (f == FLT_KEY_FIRST || f == FLT_KEY_SECOND) begin
			send_rx(8'($urandom_range(0, 255)));
			return;
		end
		send_rx(8'($urandom_range(0, 255)));
		send_rx(8'(len));
		send_rx((f == FLT_TITLE) ? byte_except(TITLE_BYTE) : TITLE_BYTE);
		if (f == FLT_TITLE) begin
			send_rx(8'($urandom_range(0, 255)));
			return;
		end
		for (int i = 0; i < len; i++)
			send_rx(8'($urandom_range(0, 255)));
		// Send a noise word and a byte, both dropped once connected
		send_noise(1'b1);
		send_rx(8'($urandom_range(0, 255)));
	endtask

	// Ignored words in idle, then a restart while the idle line runs
	task automatic test_reset_defaults();
		send_word(CMD_TICK, 8'h00, 1'b1);
		send_word(CMD_BYTE, 8'hFF, 1'b1);
		send_word(CMD_BYTE, 8'h00, 1'b1);
		send_word(2'd3, 8'hFF, 1'b1);
		send_word(CMD_START, 8'h00, 1'b1);
		send_word(CMD_TICK, 8'hFF, 1'b1);
		send_word(CMD_TICK, 8'h00, 1'b1);
		send_word(CMD_BYTE, SYNC_BYTE, 1'b1);
		send_word(CMD_START, 8'hFF, 1'b1);
		send_word(CMD_TICK, 8'h00, 1'b1);
	endtask

	// Zero idle starts bits at once, zero bit time means one tick, zero limit fails
	task automatic test_zero_times();
		wait_idle();
		write_config(8'hFF, 10'd0, 16'd0, 8'd0);
		send_word(CMD_START, 8'h00, 1'b1);
		for (int i = 0; i < 10; i++)
			send_word(CMD_TICK, 8'($urandom_range(0, 255)), 1'b1);
		send_word(CMD_BYTE, SYNC_BYTE, 1'b1);
		send_word(CMD_TICK, 8'h00, 1'b1);
	endtask

	// Mostly well-formed sequences with random settings and content
	task automatic test_random_sessions(int target);
		fault_t f;
		int r;
		int len;
		int junk;
		while (useful_items < target) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				write_config(8'($urandom_range(0, 255)),
					($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 4)),
					($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 6)),
					($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 8)));
			end
			r = $urandom_range(0, 99);
			if (r < 60)
				f = FLT_NONE;
			else if (r < 68)
				f = FLT_NO_SYNC;
			else if (r < 76)
				f = FLT_KEY_FIRST;
			else if (r < 84)
				f = FLT_KEY_SECOND;
			else if (r < 92)
				f = FLT_TITLE;
			else
				f = FLT_RESTART;
			r = $urandom_range(0, 9);
			if (r < 3)
				len = $urandom_range(0, 2);
			else if (r < 9)
				len = $urandom_range(3, 12);
			else
				len = $urandom_range(13, 40);
			if (cfg_sync_limit == 8'd0)
				junk = 0;
			else if (f == FLT_NO_SYNC)
				junk = int'(cfg_sync_limit);
			else
				junk = $urandom_range(0, int'(cfg_sync_limit) - 1);
			drive_connect(f, junk, len);
		end
	endtask

	// Widest sync search and longest identification block
	task automatic test_extremes();
		wait_idle();
		write_config(8'hA5, 10'd1, 16'd1, 8'd255);
		drive_connect(FLT_NONE, 254, 255);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_START;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ECU_ADDRESS;
		cfg_data = 16'h0000;
		cfg_ecu_addr = ECU_ADDRESS_RST;
		cfg_bit_ticks = BIT_TIME_RST;
		cfg_idle_ticks = IDLE_TIME_RST;
		cfg_sync_limit = SYNC_LIMIT_RST;
		seq_phase = SEQ_IDLE;
		clear_run();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 37;
		rx_stall_pct = 57;
		test_reset_defaults();
		test_zero_times();
		test_random_sessions(useful_items + ITEMS_PER_MODE);

		// Hold off the sender until the block has drained
		wait_idle();
		tx_idle_pct = 57;
		rx_stall_pct = 37;
		test_random_sessions(useful_items + ITEMS_PER_MODE);

		wait_idle();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		test_random_sessions(useful_items + ITEMS_PER_MODE);
		test_extremes();

		wait_idle();
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
